FILE: hw/rtl/gclp_pkg.sv
// Shared constants, types and helper functions of the gain command line parser.
package gclp_pkg;

    // Line buffer and fixed-point format.
    localparam int LINE_BUFFER_BYTES = 64;
    localparam int FRACTION_BITS     = 20;

    // Line position counter and the positions that matter.
    localparam int POS_W        = $clog2(LINE_BUFFER_BYTES);
    localparam int MIN_POS      = 4;
    localparam int LAST_POS     = LINE_BUFFER_BYTES - 1;
    localparam int LAST_NUM_POS = LINE_BUFFER_BYTES - 3;

    // Number accumulation: integer part, fraction part in millionths.
    localparam int INT_W           = 32 - FRACTION_BITS;
    localparam int FRAC_W          = 20;
    localparam int FCNT_W          = 3;
    localparam int MAX_FRAC_DIGITS = 6;
    localparam int SCALE_W         = 17;

    // Fraction conversion by reciprocal multiply with one correction step.
    localparam int RECIP_SHIFT = 20;
    localparam int RCP_W       = FRACTION_BITS + 1;
    localparam int P_W         = FRAC_W + RCP_W;
    localparam int Q_W         = FRACTION_BITS + 2;
    localparam int MUL_W       = Q_W + FRAC_W;
    localparam int NUM_W       = MUL_W + 1;

    localparam logic [RCP_W-1:0] FRAC_RECIP =
        RCP_W'((64'd1 << (FRACTION_BITS + RECIP_SHIFT)) / 64'd1000000);
    localparam logic [FRAC_W-1:0] MICRO      = FRAC_W'(1000000);
    localparam logic [FRAC_W-1:0] HALF_MICRO = FRAC_W'(500000);
    localparam logic [P_W:0]      HALF_RECIP = (P_W+1)'(1) << (RECIP_SHIFT - 1);

    // Stream widths.
    localparam int IN_TDATA_W  = 8;
    localparam int OUT_TDATA_W = 40;

    // Characters.
    localparam logic [7:0] CHAR_COLON   = 8'h3A;
    localparam logic [7:0] CHAR_V       = 8'h76;
    localparam logic [7:0] CHAR_P       = 8'h70;
    localparam logic [7:0] CHAR_I       = 8'h69;
    localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
    localparam logic [7:0] CHAR_SPACE   = 8'h20;
    localparam logic [7:0] CHAR_TAB     = 8'h09;
    localparam logic [7:0] CHAR_CR      = 8'h0D;
    localparam logic [7:0] CHAR_PLUS    = 8'h2B;
    localparam logic [7:0] CHAR_MINUS   = 8'h2D;
    localparam logic [7:0] CHAR_POINT   = 8'h2E;
    localparam logic [7:0] CHAR_ZERO    = 8'h30;
    localparam logic [7:0] CHAR_NINE    = 8'h39;

    // Gain channel codes.
    localparam logic [1:0] CH_VOLT_KP = 2'd0;
    localparam logic [1:0] CH_VOLT_KI = 2'd1;
    localparam logic [1:0] CH_CURR_KP = 2'd2;
    localparam logic [1:0] CH_CURR_KI = 2'd3;

    // Saturation limits of the gain.
    localparam logic [31:0] GAIN_MAX = 32'h7FFF_FFFF;
    localparam logic [31:0] GAIN_MIN = 32'h8000_0000;

    // Number parser phases.
    typedef enum logic [2:0] {
        PH_SPACE,
        PH_SIGN,
        PH_INT,
        PH_FRAC,
        PH_DONE
    } num_phase_t;

    // Conversion request handed from the parser to the converter.
    typedef struct packed {
        logic [1:0]        channel;
        logic              negative;
        logic              int_big;
        logic [INT_W-1:0]  int_part;
        logic [FRAC_W-1:0] frac_part;
    } conv_req_t;

    // Weight in millionths of the fraction digit at a given place.
    function automatic logic [SCALE_W-1:0] frac_scale(input logic [FCNT_W-1:0] idx);
        logic [SCALE_W-1:0] s;
        unique case (idx)
            3'd0:    s = SCALE_W'(100000);
            3'd1:    s = SCALE_W'(10000);
            3'd2:    s = SCALE_W'(1000);
            3'd3:    s = SCALE_W'(100);
            3'd4:    s = SCALE_W'(10);
            3'd5:    s = SCALE_W'(1);
            default: s = '0;
        endcase
        return s;
    endfunction

endpackage

FILE: hw/rtl/gclp_parse.sv
// Line parser: name, colon and decimal number state, and the end-of-line decision.
module gclp_parse (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  in_valid,
    input  logic [7:0]            in_byte,
    input  logic                  advance,
    output logic                  launch,
    output gclp_pkg::conv_req_t   req
);

    logic [gclp_pkg::POS_W-1:0]  pos_reg, pos_next;
    logic [7:0]                  first_reg, first_next;
    logic [7:0]                  second_reg, second_next;
    logic                        colon_reg, colon_next;
    gclp_pkg::num_phase_t        phase_reg, phase_next;
    logic                        neg_reg, neg_next;
    logic [gclp_pkg::INT_W-1:0]  int_reg, int_next;
    logic                        big_reg, big_next;
    logic [gclp_pkg::FRAC_W-1:0] frac_reg, frac_next;
    logic [gclp_pkg::FCNT_W-1:0] fcnt_reg, fcnt_next;

    logic                        is_newline;
    logic                        is_digit;
    logic                        is_space;
    logic [3:0]                  digit_val;
    logic [gclp_pkg::INT_W+3:0]  int_step;
    logic [gclp_pkg::FRAC_W+4:0] frac_add;
    logic                        int_path;
    logic                        feed_en;

    // Character classes.
    assign is_newline = (in_byte == gclp_pkg::CHAR_NEWLINE);
    assign is_digit   = (in_byte >= gclp_pkg::CHAR_ZERO) && (in_byte <= gclp_pkg::CHAR_NINE);
    assign is_space   = (in_byte == gclp_pkg::CHAR_SPACE) ||
                        ((in_byte >= gclp_pkg::CHAR_TAB) && (in_byte <= gclp_pkg::CHAR_CR));
    assign digit_val  = in_byte[3:0];

    // Integer part times ten plus the new digit, and the weighted fraction digit.
    assign int_step = (gclp_pkg::INT_W+4)'(int_reg) * (gclp_pkg::INT_W+4)'(10)
                    + (gclp_pkg::INT_W+4)'(digit_val);
    assign frac_add = (gclp_pkg::FRAC_W+5)'(digit_val) *
                      (gclp_pkg::FRAC_W+5)'(gclp_pkg::frac_scale(fcnt_reg));

    // End-of-line decision: a known name on a long enough line with a colon.
    always_comb begin
        launch      = 1'b0;
        req.channel = gclp_pkg::CH_VOLT_KP;
        if (in_valid && is_newline && (pos_reg >= gclp_pkg::POS_W'(gclp_pkg::MIN_POS))
            && colon_reg) begin
            priority if (first_reg == gclp_pkg::CHAR_V && second_reg == gclp_pkg::CHAR_P) begin
                launch      = 1'b1;
                req.channel = gclp_pkg::CH_VOLT_KP;
            end else if (first_reg == gclp_pkg::CHAR_V && second_reg == gclp_pkg::CHAR_I) begin
                launch      = 1'b1;
                req.channel = gclp_pkg::CH_VOLT_KI;
            end else if (first_reg == gclp_pkg::CHAR_I && second_reg == gclp_pkg::CHAR_P) begin
                launch      = 1'b1;
                req.channel = gclp_pkg::CH_CURR_KP;
            end else if (first_reg == gclp_pkg::CHAR_I && second_reg == gclp_pkg::CHAR_I) begin
                launch      = 1'b1;
                req.channel = gclp_pkg::CH_CURR_KI;
            end else begin
                launch      = 1'b0;
            end
        end
        req.negative  = neg_reg;
        req.int_big   = big_reg;
        req.int_part  = int_reg;
        req.frac_part = frac_reg;
    end

    // Next line state for the character that leaves the input register.
    always_comb begin
        pos_next    = pos_reg;
        first_next  = first_reg;
        second_next = second_reg;
        colon_next  = colon_reg;
        phase_next  = phase_reg;
        neg_next    = neg_reg;
        int_next    = int_reg;
        big_next    = big_reg;
        frac_next   = frac_reg;
        fcnt_next   = fcnt_reg;
        int_path    = 1'b0;
        feed_en     = 1'b0;

        if (advance) begin
            if (is_newline) begin
                pos_next    = '0;
                first_next  = '0;
                second_next = '0;
                colon_next  = 1'b0;
                phase_next  = gclp_pkg::PH_SPACE;
                neg_next    = 1'b0;
                int_next    = '0;
                big_next    = 1'b0;
                frac_next   = '0;
                fcnt_next   = '0;
            end else if (pos_reg < gclp_pkg::POS_W'(gclp_pkg::LAST_POS)) begin
                priority if (pos_reg == gclp_pkg::POS_W'(0)) begin
                    first_next = in_byte;
                end else if (pos_reg == gclp_pkg::POS_W'(1)) begin
                    second_next = in_byte;
                end else if (pos_reg == gclp_pkg::POS_W'(2)) begin
                    colon_next = (in_byte == gclp_pkg::CHAR_COLON);
                end else if (pos_reg <= gclp_pkg::POS_W'(gclp_pkg::LAST_NUM_POS)) begin
                    feed_en = 1'b1;
                end else begin
                    feed_en = 1'b0;
                end
                pos_next = pos_reg + gclp_pkg::POS_W'(1);
            end
        end

        // Number parser: spaces, sign, integer digits, point, fraction digits.
        if (feed_en) begin
            unique case (phase_reg)
                gclp_pkg::PH_SPACE: begin
                    if (is_space) begin
                        phase_next = gclp_pkg::PH_SPACE;
                    end else if (in_byte == gclp_pkg::CHAR_PLUS ||
                                 in_byte == gclp_pkg::CHAR_MINUS) begin
                        neg_next   = (in_byte == gclp_pkg::CHAR_MINUS);
                        phase_next = gclp_pkg::PH_SIGN;
                    end else begin
                        int_path = 1'b1;
                    end
                end
                gclp_pkg::PH_SIGN, gclp_pkg::PH_INT: begin
                    int_path = 1'b1;
                end
                gclp_pkg::PH_FRAC: begin
                    if (is_digit &&
                        fcnt_reg < gclp_pkg::FCNT_W'(gclp_pkg::MAX_FRAC_DIGITS)) begin
                        frac_next = frac_reg + frac_add[gclp_pkg::FRAC_W-1:0];
                        fcnt_next = fcnt_reg + gclp_pkg::FCNT_W'(1);
                    end else begin
                        phase_next = gclp_pkg::PH_DONE;
                    end
                end
                gclp_pkg::PH_DONE: begin
                    phase_next = gclp_pkg::PH_DONE;
                end
                default: begin
                    phase_next = gclp_pkg::PH_DONE;
                end
            endcase

            // Integer handling, shared by the sign, integer and leading-space phases.
            if (int_path) begin
                if (is_digit) begin
                    int_next   = int_step[gclp_pkg::INT_W-1:0];
                    big_next   = big_reg || (int_step[gclp_pkg::INT_W+3:gclp_pkg::INT_W] != '0);
                    phase_next = gclp_pkg::PH_INT;
                end else if (in_byte == gclp_pkg::CHAR_POINT) begin
                    phase_next = gclp_pkg::PH_FRAC;
                end else begin
                    phase_next = gclp_pkg::PH_DONE;
                end
            end
        end
    end

    // Phase register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= gclp_pkg::PH_SPACE;
        end else begin
            phase_reg <= phase_next;
        end
    end

    // Line state registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg    <= '0;
            first_reg  <= '0;
            second_reg <= '0;
            colon_reg  <= 1'b0;
            neg_reg    <= 1'b0;
            int_reg    <= '0;
            big_reg    <= 1'b0;
            frac_reg   <= '0;
            fcnt_reg   <= '0;
        end else begin
            pos_reg    <= pos_next;
            first_reg  <= first_next;
            second_reg <= second_next;
            colon_reg  <= colon_next;
            neg_reg    <= neg_next;
            int_reg    <= int_next;
            big_reg    <= big_next;
            frac_reg   <= frac_next;
            fcnt_reg   <= fcnt_next;
        end
    end

endmodule

FILE: hw/rtl/gclp_conv.sv
// Pipelined conversion of integer part and millionths to saturated signed fixed point.
module gclp_conv (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  gclp_pkg::conv_req_t   req,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [1:0]            out_channel,
    output logic [31:0]           out_gain
);

    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg;
    logic rdy1, rdy2, rdy3, rdy4, rdy5;

    gclp_pkg::conv_req_t          req1_reg, req2_reg, req3_reg, req4_reg;
    logic [gclp_pkg::P_W-1:0]     p2_reg, p2_next;
    logic [gclp_pkg::Q_W-1:0]     q3_reg, q3_next;
    logic [gclp_pkg::MUL_W-1:0]   prod3_reg, prod3_next;
    logic [gclp_pkg::Q_W-1:0]     frac4_reg, frac4_next;
    logic [1:0]                   ch5_reg;
    logic [31:0]                  gain5_reg, gain5_next;

    logic [gclp_pkg::P_W:0]       p_round;
    logic [gclp_pkg::NUM_W-1:0]   num;
    logic [gclp_pkg::NUM_W-1:0]   thr;
    logic [32:0]                  mag;

    // Each stage moves on when it is empty or the stage after it moves on.
    assign rdy5     = !v5_reg || out_ready;
    assign rdy4     = !v4_reg || rdy5;
    assign rdy3     = !v3_reg || rdy4;
    assign rdy2     = !v2_reg || rdy3;
    assign rdy1     = !v1_reg || rdy2;
    assign in_ready = rdy1;

    // Stage 2: millionths times the reciprocal of one million.
    assign p2_next = gclp_pkg::P_W'(req1_reg.frac_part) * gclp_pkg::P_W'(gclp_pkg::FRAC_RECIP);

    // Stage 3: rounded estimate of the fraction bits and its back product.
    assign p_round    = (gclp_pkg::P_W+1)'(p2_reg) + gclp_pkg::HALF_RECIP;
    assign q3_next    = p_round[gclp_pkg::P_W:gclp_pkg::RECIP_SHIFT];
    assign prod3_next = gclp_pkg::MUL_W'(q3_next) * gclp_pkg::MUL_W'(gclp_pkg::MICRO);

    // Stage 4: the estimate is low by at most one; one compare corrects it.
    assign num = gclp_pkg::NUM_W'({req3_reg.frac_part, {gclp_pkg::FRACTION_BITS{1'b0}}})
               + gclp_pkg::NUM_W'(gclp_pkg::HALF_MICRO);
    assign thr = gclp_pkg::NUM_W'(prod3_reg) + gclp_pkg::NUM_W'(gclp_pkg::MICRO);
    assign frac4_next = q3_reg + gclp_pkg::Q_W'(num >= thr);

    // Stage 5: join integer and fraction, apply sign and saturate.
    assign mag = 33'({req4_reg.int_part, {gclp_pkg::FRACTION_BITS{1'b0}}}) + 33'(frac4_reg);
    always_comb begin
        if (req4_reg.negative) begin
            if (req4_reg.int_big || mag >= 33'h0_8000_0000) begin
                gain5_next = gclp_pkg::GAIN_MIN;
            end else begin
                gain5_next = 32'd0 - mag[31:0];
            end
        end else begin
            if (req4_reg.int_big || mag > 33'(gclp_pkg::GAIN_MAX)) begin
                gain5_next = gclp_pkg::GAIN_MAX;
            end else begin
                gain5_next = mag[31:0];
            end
        end
    end

    // Stage valid bits.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end else begin
            if (rdy1) v1_reg <= in_valid;
            if (rdy2) v2_reg <= v1_reg;
            if (rdy3) v3_reg <= v2_reg;
            if (rdy4) v4_reg <= v3_reg;
            if (rdy5) v5_reg <= v4_reg;
        end
    end

    // Stage payloads.
    always_ff @(posedge aclk) begin
        if (rdy1 && in_valid) begin
            req1_reg <= req;
        end
        if (rdy2 && v1_reg) begin
            req2_reg <= req1_reg;
            p2_reg   <= p2_next;
        end
        if (rdy3 && v2_reg) begin
            req3_reg  <= req2_reg;
            q3_reg    <= q3_next;
            prod3_reg <= prod3_next;
        end
        if (rdy4 && v3_reg) begin
            req4_reg  <= req3_reg;
            frac4_reg <= frac4_next;
        end
        if (rdy5 && v4_reg) begin
            ch5_reg   <= req4_reg.channel;
            gain5_reg <= gain5_next;
        end
    end

    assign out_valid   = v5_reg;
    assign out_channel = ch5_reg;
    assign out_gain    = gain5_reg;

endmodule

FILE: hw/rtl/gain_command_line_parser.sv
// Top level of the gain command line parser: input register, parser and converter.
// Throughput: one character per cycle; s_tready stays high unless every conversion
// stage is full and the result waits on m_tready.
// Latency: a result reaches m_tvalid after the newline transaction through the input register,
// four conversion stages and the result register, and is held back longer under stall.
// Reset: aresetn low clears the line state, the number parser and all valid bits.
module gain_command_line_parser (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [gclp_pkg::IN_TDATA_W-1:0]     s_tdata,  // [7:0] rx_byte
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [gclp_pkg::OUT_TDATA_W-1:0]    m_tdata   // [1:0] channel, [33:2] gain_value
);

    logic                 byte_valid_reg;
    logic [7:0]           byte_reg;
    logic                 launch;
    logic                 advance;
    logic                 conv_ready;
    logic [1:0]           out_channel;
    logic [31:0]          out_gain;
    gclp_pkg::conv_req_t  req;

    // A character leaves the input register unless it needs a full converter.
    assign advance  = byte_valid_reg && (!launch || conv_ready);
    assign s_tready = !byte_valid_reg || advance;

    // Input register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            byte_valid_reg <= 1'b0;
        end else if (s_tready) begin
            byte_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            byte_reg <= s_tdata;
        end
    end

    gclp_parse u_parse (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (byte_valid_reg),
        .in_byte  (byte_reg),
        .advance  (advance),
        .launch   (launch),
        .req      (req)
    );

    gclp_conv u_conv (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_valid    (launch),
        .in_ready    (conv_ready),
        .req         (req),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .out_channel (out_channel),
        .out_gain    (out_gain)
    );

    // Result transaction packing, padded to whole bytes.
    assign m_tdata = {6'b0, out_gain, out_channel};

endmodule

FILE: hw/rtl/gclp_checker.sv
// Port-level checker for the gain command line parser, bound to the top level.
module gclp_checker (
    input logic                              aclk,
    input logic                              aresetn,
    input logic                              s_tvalid,
    input logic                              s_tready,
    input logic [gclp_pkg::IN_TDATA_W-1:0]   s_tdata,
    input logic                              m_tvalid,
    input logic                              m_tready,
    input logic [gclp_pkg::OUT_TDATA_W-1:0]  m_tdata
);

    // A stalled result holds its valid and its data.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

    // Reset empties the result register.
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    // Input back-pressure only arises from a waiting result.
    a_ready_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> m_tvalid && !m_tready)
        else $error("input stalled without a waiting result");

    // Padding bits above the gain stay zero.
    a_pad_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[gclp_pkg::OUT_TDATA_W-1:34] == '0)
        else $error("nonzero padding in result");

endmodule

bind gain_command_line_parser gclp_checker u_gclp_checker (.*);

FILE: tb/tb_gain_command_line_parser.sv
// Self-checking testbench for the gain command line parser stream block.
module tb_gain_command_line_parser;

    import gclp_pkg::*;

    localparam int          IDLE_PERCENT  = 27;
    localparam int          RANDOM_BYTES  = 720;
    localparam int          CYCLE_LIMIT   = 400000;
    localparam int          DRAIN_CYCLES  = 16;
    localparam int          NUM_ROWS      = 25;
    localparam logic [63:0] ONE_MILLION   = 64'd1000000;
    localparam logic [63:0] MILLIONTH_CAP = 64'd1 << 50;
    localparam logic [63:0] PLACE_WEIGHT [MAX_FRAC_DIGITS] =
        '{64'd100000, 64'd10000, 64'd1000, 64'd100, 64'd10, 64'd1};

    // How the expected result of a directed line is obtained.
    typedef enum logic [1:0] {
        ROW_PREDICTED,
        ROW_NO_UPDATE,
        ROW_TYPED
    } row_kind_t;

    typedef struct {
        logic [1:0]  channel;
        logic [31:0] gain;
    } gain_update_t;

    // One directed command line: head, a run of fill characters, tail, newline.
    typedef struct {
        string       head;
        logic [7:0]  fill;
        int          fill_len;
        string       tail;
        row_kind_t   kind;
        logic [1:0]  channel;
        logic [31:0] gain;
    } command_row_t;

    logic                   aclk = 1'b0;
    logic                   aresetn = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata = '0;  // [7:0] rx_byte
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;       // [1:0] channel, [33:2] gain_value

    // Predicted line parser state.
    int unsigned  line_len;
    logic [7:0]   first_char;
    logic [7:0]   second_char;
    bit           colon_ok;
    num_phase_t   num_phase;
    bit           negative;
    logic [63:0]  millionths;
    int unsigned  frac_digits;

    gain_update_t pending_updates [$];
    logic [7:0]   line_bytes [$];
    int           mismatch_count = 0;
    int           bytes_sent = 0;
    int           random_start = 0;
    int           cycle_count = 0;
    bit           steady = 1'b0;

    string gain_names [4] = '{"vp", "vi", "ip", "ii"};
    logic [7:0] blank_chars [5] = '{CHAR_SPACE, CHAR_TAB, 8'h0B, 8'h0C, CHAR_CR};
    string long_line_chars = "0123456789 .-";

    command_row_t directed_rows [NUM_ROWS] = '{
        '{"vp:1",           8'h00,        0,  "",   ROW_TYPED,     CH_VOLT_KP, 32'h0010_0000},
        '{"vi:-1",          8'h00,        0,  "",   ROW_TYPED,     CH_VOLT_KI, 32'hFFF0_0000},
        '{"ip:0",           8'h00,        0,  "",   ROW_TYPED,     CH_CURR_KP, 32'h0000_0000},
        '{"ii:-0",          8'h00,        0,  "",   ROW_TYPED,     CH_CURR_KI, 32'h0000_0000},
        '{"ii:-",           8'h00,        0,  "",   ROW_TYPED,     CH_CURR_KI, 32'h0000_0000},
        '{"vp:",            8'h00,        0,  "",   ROW_NO_UPDATE, CH_VOLT_KP, 32'h0},
        '{"vp:x",           8'h00,        0,  "",   ROW_TYPED,     CH_VOLT_KP, 32'h0000_0000},
        '{"xy:5",           8'h00,        0,  "",   ROW_NO_UPDATE, CH_VOLT_KP, 32'h0},
        '{"vp-5",           8'h00,        0,  "",   ROW_NO_UPDATE, CH_VOLT_KP, 32'h0},
        '{"vp:99999999",    8'h00,        0,  "",   ROW_TYPED,     CH_VOLT_KP, GAIN_MAX},
        '{"vi:-99999999",   8'h00,        0,  "",   ROW_TYPED,     CH_VOLT_KI, GAIN_MIN},
        '{"ip:2048",        8'h00,        0,  "",   ROW_TYPED,     CH_CURR_KP, GAIN_MAX},
        '{"ip:-2048",       8'h00,        0,  "",   ROW_TYPED,     CH_CURR_KP, GAIN_MIN},
        '{"ii:2047.999999", 8'h00,        0,  "",   ROW_PREDICTED, CH_CURR_KI, 32'h0},
        '{"vp:  \t+3.25",   8'h00,        0,  "",   ROW_TYPED,     CH_VOLT_KP, 32'h0034_0000},
        '{"vi:0.1234567",   8'h00,        0,  "",   ROW_PREDICTED, CH_VOLT_KI, 32'h0},
        '{"vp:1e5",         8'h00,        0,  "",   ROW_TYPED,     CH_VOLT_KP, 32'h0010_0000},
        '{"ip:.5",          8'h00,        0,  "",   ROW_TYPED,     CH_CURR_KP, 32'h0008_0000},
        '{"vp:",            CHAR_SPACE,   58, "7",  ROW_TYPED,     CH_VOLT_KP, 32'h0070_0000},
        '{"vp:",            CHAR_SPACE,   59, "7",  ROW_TYPED,     CH_VOLT_KP, 32'h0000_0000},
        '{"ii:1",           CHAR_ZERO,    80, "",   ROW_TYPED,     CH_CURR_KI, GAIN_MAX},
        '{"",               8'h00,        2,  ":5", ROW_NO_UPDATE, CH_VOLT_KP, 32'h0},
        '{"vp:",            8'hFF,        3,  "",   ROW_TYPED,     CH_VOLT_KP, 32'h0000_0000},
        '{"",               8'h00,        0,  "",   ROW_NO_UPDATE, CH_VOLT_KP, 32'h0},
        '{"ii:-3.9999995",  8'h00,        0,  "",   ROW_PREDICTED, CH_CURR_KI, 32'h0}
    };

    gain_command_line_parser uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // Two time units per clock period.
    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // Prints one line per mismatch and keeps the count.
    task automatic report_mismatch(input string what);
        $display("MISMATCH at cycle %0d: %s", cycle_count, what);
        mismatch_count++;
    endtask

    // Starts a fresh command line in the predicted state.
    function automatic void clear_predicted_line();
        line_len    = 0;
        first_char  = '0;
        second_char = '0;
        colon_ok    = 1'b0;
        num_phase   = PH_SPACE;
        negative    = 1'b0;
        millionths  = '0;
        frac_digits = 0;
    endfunction

    // Advances the decimal number parser by one character.
    function automatic void take_number_char(input logic [7:0] c);
        bit          is_digit;
        logic [63:0] digit;
        is_digit = (c >= CHAR_ZERO) && (c <= CHAR_NINE);
        digit    = 64'(c[3:0]);
        if (num_phase == PH_SPACE) begin
            if (c == CHAR_SPACE || (c >= CHAR_TAB && c <= CHAR_CR)) begin
                return;
            end
            if (c == CHAR_PLUS || c == CHAR_MINUS) begin
                negative  = (c == CHAR_MINUS);
                num_phase = PH_SIGN;
                return;
            end
        end
        case (num_phase)
            PH_SPACE, PH_SIGN, PH_INT: begin
                if (is_digit) begin
                    millionths = millionths * 10 + digit * ONE_MILLION;
                    if (millionths > MILLIONTH_CAP) begin
                        millionths = MILLIONTH_CAP;
                    end
                    num_phase = PH_INT;
                end else if (c == CHAR_POINT) begin
                    num_phase = PH_FRAC;
                end else begin
                    num_phase = PH_DONE;
                end
            end
            PH_FRAC: begin
                if (is_digit && frac_digits < MAX_FRAC_DIGITS) begin
                    millionths = millionths + digit * PLACE_WEIGHT[frac_digits];
                    if (millionths > MILLIONTH_CAP) begin
                        millionths = MILLIONTH_CAP;
                    end
                    frac_digits++;
                end else begin
                    num_phase = PH_DONE;
                end
            end
            default: begin
                num_phase = PH_DONE;
            end
        endcase
    endfunction

    // Rounds the value in millionths to signed fixed point and saturates it.
    function automatic logic [31:0] predicted_gain();
        logic [63:0] whole;
        logic [63:0] part;
        logic [63:0] mag;
        logic [63:0] negated;
        whole = millionths / ONE_MILLION;
        part  = millionths % ONE_MILLION;
        if (whole >= (64'd1 << (32 - FRACTION_BITS))) begin
            mag = 64'd1 << 32;
        end else begin
            mag = (whole << FRACTION_BITS) +
                  ((part << FRACTION_BITS) + ONE_MILLION / 2) / ONE_MILLION;
        end
        if (negative) begin
            if (mag >= 64'h8000_0000) begin
                return GAIN_MIN;
            end
            negated = 64'd0 - mag;
            return negated[31:0];
        end
        if (mag > 64'h7FFF_FFFF) begin
            return GAIN_MAX;
        end
        return mag[31:0];
    endfunction

    // Tracks one accepted character; a newline on a known command yields an update.
    function automatic void track_rx_char(input logic [7:0] c, output bit produced,
                                          output gain_update_t upd);
        produced    = 1'b0;
        upd.channel = CH_VOLT_KP;
        upd.gain    = '0;
        if (c == CHAR_NEWLINE) begin
            if (line_len >= MIN_POS && colon_ok) begin
                produced = 1'b1;
                if (first_char == CHAR_V && second_char == CHAR_P) begin
                    upd.channel = CH_VOLT_KP;
                end else if (first_char == CHAR_V && second_char == CHAR_I) begin
                    upd.channel = CH_VOLT_KI;
                end else if (first_char == CHAR_I && second_char == CHAR_P) begin
                    upd.channel = CH_CURR_KP;
                end else if (first_char == CHAR_I && second_char == CHAR_I) begin
                    upd.channel = CH_CURR_KI;
                end else begin
                    produced = 1'b0;
                end
                upd.gain = predicted_gain();
            end
            clear_predicted_line();
            return;
        end
        if (line_len < LAST_POS) begin
            if (line_len == 0) begin
                first_char = c;
            end else if (line_len == 1) begin
                second_char = c;
            end else if (line_len == 2) begin
                colon_ok = (c == CHAR_COLON);
            end else if (line_len <= LAST_NUM_POS) begin
                take_number_char(c);
            end
            line_len++;
        end
    endfunction

    // Fills the line buffer with a random command line, mostly well formed.
    function automatic void compose_random_line();
        int         pick;
        int         n;
        string      name;
        logic [7:0] b;
        line_bytes.delete();
        pick = $urandom_range(99);
        if (pick < 8) begin
            // Pure noise.
            n = $urandom_range(1, 12);
            repeat (n) line_bytes.push_back(8'($urandom_range(255)));
        end else if (pick < 12) begin
            // Long line that can run past the buffer.
            name = gain_names[$urandom_range(3)];
            line_bytes.push_back(name[0]);
            line_bytes.push_back(name[1]);
            line_bytes.push_back(CHAR_COLON);
            n = $urandom_range(55, 75);
            repeat (n) begin
                line_bytes.push_back(long_line_chars[$urandom_range(long_line_chars.len() - 1)]);
            end
        end else begin
            if ($urandom_range(99) < 85) begin
                name = gain_names[$urandom_range(3)];
                line_bytes.push_back(name[0]);
                line_bytes.push_back(name[1]);
            end else begin
                line_bytes.push_back(8'($urandom_range(255)));
                line_bytes.push_back(8'($urandom_range(255)));
            end
            line_bytes.push_back(($urandom_range(99) < 92) ? CHAR_COLON
                                                            : 8'($urandom_range(255)));
            repeat ($urandom_range(0, 3)) line_bytes.push_back(blank_chars[$urandom_range(4)]);
            case ($urandom_range(2))
                0: line_bytes.push_back(CHAR_PLUS);
                1: line_bytes.push_back(CHAR_MINUS);
                default: ;
            endcase
            n = ($urandom_range(9) == 0) ? $urandom_range(5, 12) : $urandom_range(0, 4);
            repeat (n) line_bytes.push_back(8'(CHAR_ZERO + $urandom_range(9)));
            if ($urandom_range(99) < 60) begin
                line_bytes.push_back(CHAR_POINT);
                repeat ($urandom_range(0, 8)) line_bytes.push_back(8'(CHAR_ZERO + $urandom_range(9)));
            end
            if ($urandom_range(99) < 20) begin
                b = 8'($urandom_range(255));
                if (b != CHAR_NEWLINE) begin
                    line_bytes.push_back(b);
                end
            end
        end
        line_bytes.push_back(CHAR_NEWLINE);
    endfunction

    // Offers one character at a falling edge and waits for its transaction.
    task automatic send_char(input logic [7:0] c, output bit produced,
                             output gain_update_t upd);
        steady = (bytes_sent >= random_start + 400) && (bytes_sent < random_start + 650)
                 && (random_start != 0);
        while (!steady && $urandom_range(99) < IDLE_PERCENT) begin
            s_tvalid = 1'b0;
            @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tdata  = c;
        do @(posedge aclk); while (!s_tready);
        track_rx_char(c, produced, upd);
        bytes_sent++;
        @(negedge aclk);
        s_tvalid = 1'b0;
    endtask

    // Sends the line buffer and queues the expected gain updates.
    task automatic send_line(input row_kind_t kind, input logic [1:0] channel,
                             input logic [31:0] gain);
        bit           produced;
        gain_update_t upd;
        gain_update_t typed;
        typed.channel = channel;
        typed.gain    = gain;
        foreach (line_bytes[i]) begin
            send_char(line_bytes[i], produced, upd);
            if (kind == ROW_PREDICTED && produced) begin
                pending_updates.push_back(upd);
            end else if (kind == ROW_TYPED && i == line_bytes.size() - 1) begin
                pending_updates.push_back(typed);
            end
        end
    endtask

    // The result side stalls at random except in the steady stretch.
    always @(negedge aclk) begin
        m_tready <= steady || ($urandom_range(99) >= IDLE_PERCENT);
    end

    // Compare each result transaction with the oldest expected update.
    always @(posedge aclk) begin
        gain_update_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_updates.size() == 0) begin
                report_mismatch($sformatf("unexpected update ch %0d gain %h",
                                          m_tdata[1:0], m_tdata[33:2]));
            end else begin
                want = pending_updates.pop_front();
                if (m_tdata[1:0] !== want.channel) begin
                    report_mismatch($sformatf("channel %0d, expected %0d",
                                              m_tdata[1:0], want.channel));
                end
                if (m_tdata[33:2] !== want.gain) begin
                    report_mismatch($sformatf("gain %h, expected %h on channel %0d",
                                              m_tdata[33:2], want.gain, want.channel));
                end
            end
        end
    end

    // Hard limit on the run length.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // Stimulus sequence.
    initial begin
        bit drained_once;
        drained_once = 1'b0;
        clear_predicted_line();
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // Directed command lines.
        foreach (directed_rows[r]) begin
            line_bytes.delete();
            for (int i = 0; i < directed_rows[r].head.len(); i++) begin
                line_bytes.push_back(directed_rows[r].head[i]);
            end
            repeat (directed_rows[r].fill_len) line_bytes.push_back(directed_rows[r].fill);
            for (int i = 0; i < directed_rows[r].tail.len(); i++) begin
                line_bytes.push_back(directed_rows[r].tail[i]);
            end
            line_bytes.push_back(CHAR_NEWLINE);
            send_line(directed_rows[r].kind, directed_rows[r].channel, directed_rows[r].gain);
        end

        // Random command lines, with one pause until every update is out.
        random_start = bytes_sent;
        while (bytes_sent < random_start + RANDOM_BYTES) begin
            if (!drained_once && bytes_sent >= random_start + 300) begin
                while (pending_updates.size() != 0) @(negedge aclk);
                drained_once = 1'b1;
            end
            compose_random_line();
            send_line(ROW_PREDICTED, CH_VOLT_KP, 32'h0);
        end

        // Let the pipeline empty.
        while (pending_updates.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (pending_updates.size() != 0) begin
            report_mismatch($sformatf("%0d updates never arrived", pending_updates.size()));
        end
        if (mismatch_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
